@@ design/descriptor_tracking_table_core_macros.svh @@
// Assertion macros for the checker file of the tracking table.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef DESCRIPTOR_TRACKING_TABLE_CORE_MACROS_SVH
`define DESCRIPTOR_TRACKING_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/dtt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dtt_pkg;

	localparam int DESC_W     = 16;
	localparam int OP_W       = 64;
	localparam int POS_W      = 64;
	localparam int LEN_W      = 31;
	localparam int SEED_W     = 32;
	localparam int LOCK_OUT_W = 8;
	localparam int STATUS_W   = 2;
	localparam int ACTION_W   = 3;

	localparam int S_TDATA_W = 88;
	localparam int S_TUSER_W = ACTION_W;
	localparam int M_TDATA_W = 144;
	localparam int M_TUSER_W = STATUS_W;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_BASE_SEED = 1'b0;
	localparam logic REG_AUTO_INC  = 1'b1;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_REGISTER   = 3'd0,
		ACT_UNREGISTER = 3'd1,
		ACT_LOCK       = 3'd2,
		ACT_UNLOCK     = 3'd3,
		ACT_SET_POS    = 3'd4,
		ACT_ADD_POS    = 3'd5,
		ACT_SET_FUZZED = 3'd6,
		ACT_QUERY      = 3'd7
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_NOT_WATCHED = 2'd1,
		ST_EXISTS      = 2'd2,
		ST_NO_SLOT     = 2'd3
	} status_t;

	typedef struct packed {
		logic slot_we;
		logic map_we;
		logic map_valid;
		logic use_set;
		logic use_clr;
		logic seed_adv;
	} upd_ctl_t;

	typedef struct packed {
		status_t                 status;
		logic                    watched;
		logic [LOCK_OUT_W-1:0]   lock;
		logic                    active;
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        wstart;
		logic [LEN_W-1:0]        wlen;
		logic [SEED_W-1:0]       seed;
	} rep_in_t;

endpackage
`default_nettype wire

@@ design/dtt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/dtt_slot_upd.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtt_slot_upd #(
	parameter int LOCK_BITS = 8,
	parameter int SLOT_AW = 5
) (
	input  dtt_pkg::action_t                action,
	input  logic                            inrange,
	input  logic                            have,
	input  logic [SLOT_AW-1:0]              slot_idx,
	input  logic                            free_found,
	input  logic [SLOT_AW-1:0]              free_idx,
	input  logic [dtt_pkg::OP_W-1:0]        operand,
	input  logic                            act_in,
	input  logic [dtt_pkg::SEED_W-1:0]      next_seed,
	input  logic [LOCK_BITS-1:0]            old_locks,
	input  logic                            old_active,
	input  logic [dtt_pkg::POS_W-1:0]       old_pos,
	input  logic [dtt_pkg::POS_W-1:0]       old_wstart,
	input  logic [dtt_pkg::LEN_W-1:0]       old_wlen,
	input  logic [dtt_pkg::SEED_W-1:0]      old_seed,
	output dtt_pkg::upd_ctl_t               ctl,
	output logic [SLOT_AW-1:0]              wr_idx,
	output logic [LOCK_BITS-1:0]            new_locks,
	output logic                            new_active,
	output logic [dtt_pkg::POS_W-1:0]       new_pos,
	output logic [dtt_pkg::POS_W-1:0]       new_wstart,
	output logic [dtt_pkg::LEN_W-1:0]       new_wlen,
	output logic [dtt_pkg::SEED_W-1:0]      new_seed,
	output dtt_pkg::rep_in_t                rep
);
	import dtt_pkg::*;

	logic [LEN_W-1:0] cnt;
	logic             have_rep;
	status_t          status;

	// Fuzzed byte count clamped into the window length range.
	always_comb begin
		if (operand[OP_W-1]) begin
			cnt = '0;
		end else if (operand[OP_W-2:LEN_W] != '0) begin
			cnt = LEN_MAX;
		end else begin
			cnt = operand[LEN_W-1:0];
		end
	end

	always_comb begin
		ctl        = '0;
		wr_idx     = slot_idx;
		new_locks  = old_locks;
		new_active = old_active;
		new_pos    = old_pos;
		new_wstart = old_wstart;
		new_wlen   = old_wlen;
		new_seed   = old_seed;
		have_rep   = have;
		status     = ST_OK;
		case (action)
			ACT_REGISTER: begin
				if (!inrange) begin
					status   = ST_EXISTS;
					have_rep = 1'b0;
				end else if (have) begin
					status = ST_EXISTS;
				end else if (!free_found) begin
					status   = ST_NO_SLOT;
					have_rep = 1'b0;
				end else begin
					ctl.slot_we   = 1'b1;
					ctl.map_we    = 1'b1;
					ctl.map_valid = 1'b1;
					ctl.use_set   = 1'b1;
					ctl.seed_adv  = 1'b1;
					wr_idx        = free_idx;
					new_locks     = '0;
					new_active    = act_in;
					new_pos       = '0;
					new_wstart    = '0;
					new_wlen      = '0;
					new_seed      = next_seed;
					have_rep      = 1'b1;
				end
			end
			default: begin
				if (!have) begin
					status   = ST_NOT_WATCHED;
					have_rep = 1'b0;
				end else begin
					case (action)
						ACT_UNREGISTER: begin
							ctl.map_we  = 1'b1;
							ctl.use_clr = 1'b1;
							have_rep    = 1'b0;
						end
						ACT_LOCK: begin
							ctl.slot_we = 1'b1;
							if (old_locks != '1) begin
								new_locks = old_locks + LOCK_BITS'(1);
							end
						end
						ACT_UNLOCK: begin
							ctl.slot_we = 1'b1;
							if (old_locks != '0) begin
								new_locks = old_locks - LOCK_BITS'(1);
							end
						end
						ACT_SET_POS: begin
							ctl.slot_we = 1'b1;
							new_pos     = operand;
						end
						ACT_ADD_POS: begin
							ctl.slot_we = 1'b1;
							new_pos     = old_pos + operand;
						end
						ACT_SET_FUZZED: begin
							ctl.slot_we = 1'b1;
							// A new window is taken only when the position moved or it grew.
							if (old_pos != old_wstart || cnt > old_wlen) begin
								new_wstart = old_pos;
								new_wlen   = cnt;
							end
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin
		rep.status  = status;
		rep.watched = have_rep;
		rep.lock    = have_rep ? LOCK_OUT_W'(new_locks) : '0;
		rep.active  = have_rep ? new_active : 1'b1;
		rep.pos     = have_rep ? new_pos : '0;
		rep.wstart  = have_rep ? new_wstart : '0;
		rep.wlen    = have_rep ? new_wlen : '0;
		rep.seed    = have_rep ? new_seed : '0;
	end

endmodule
`default_nettype wire

@@ design/dtt_report.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtt_report (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dtt_pkg::rep_in_t                in_rep,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dtt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic [dtt_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
	import dtt_pkg::*;

	typedef struct packed {
		status_t               status;
		logic                  watched;
		logic [LOCK_OUT_W-1:0] lock;
		logic                  active;
		logic [POS_W-1:0]      pos;
		logic [SEED_W-1:0]     seed;
		logic                  ge;
		logic                  hi_zero;
		logic [LEN_W-1:0]      d_lo;
		logic [LEN_W-1:0]      wlen;
	} win_t;

	logic             s3_v_q;
	rep_in_t          rep_s3;
	logic             s4_v_q;
	win_t             win_s4;
	logic             out_v_q;
	logic [M_TDATA_W-1:0] tdata_q;
	logic [M_TUSER_W-1:0] tuser_q;

	logic             out_ld;
	logic             s4_free;
	logic             s3_mv;
	logic [POS_W:0]   diff;
	logic [LEN_W:0]   rem;
	logic [LEN_W-1:0] left;
	win_t             win_d;

	assign out_ld   = s4_v_q && (!out_v_q || m_axis_tready);
	assign s4_free  = !s4_v_q || out_ld;
	assign s3_mv    = s3_v_q && s4_free;
	assign in_ready = !s3_v_q || s3_mv;

	// Signed distance from the window start; never overflows at 65 bits.
	always_comb begin
		diff           = {rep_s3.pos[POS_W-1], rep_s3.pos}
			- {rep_s3.wstart[POS_W-1], rep_s3.wstart};
		win_d.status   = rep_s3.status;
		win_d.watched  = rep_s3.watched;
		win_d.lock     = rep_s3.lock;
		win_d.active   = rep_s3.active;
		win_d.pos      = rep_s3.pos;
		win_d.seed     = rep_s3.seed;
		win_d.ge       = !diff[POS_W];
		win_d.hi_zero  = diff[POS_W-1:LEN_W] == '0;
		win_d.d_lo     = diff[LEN_W-1:0];
		win_d.wlen     = rep_s3.wlen;
	end

	always_comb begin
		rem  = {1'b0, win_s4.wlen} - {1'b0, win_s4.d_lo};
		left = (win_s4.ge && win_s4.hi_zero && !rem[LEN_W]) ? rem[LEN_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q  <= 1'b0;
			s4_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s3_v_q <= 1'b1;
			end else if (s3_mv) begin
				s3_v_q <= 1'b0;
			end
			if (s3_mv) begin
				s4_v_q <= 1'b1;
			end else if (out_ld) begin
				s4_v_q <= 1'b0;
			end
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rep_s3 <= in_rep;
		end
		if (s3_mv) begin
			win_s4 <= win_d;
		end
		if (out_ld) begin
			tdata_q <= M_TDATA_W'({win_s4.seed, left, win_s4.pos, win_s4.active,
				win_s4.lock, win_s4.watched});
			tuser_q <= win_s4.status;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

endmodule
`default_nettype wire

@@ design/descriptor_tracking_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Descriptor tracking table: maps descriptor numbers below DESCRIPTOR_LIMIT onto NUM_SLOTS
// tracking slots and answers every input item with exactly one result item that describes
// the descriptor after the action. The descriptor map and the slot contents each live in a
// synchronous RAM; an item reads the map, then reads its slot, and writes both back in stage 2
// once the report path can take its result. A new item is not taken while the one before it
// is in stage 1; its map read may overlap the write-back of the one before it and is then
// forwarded from that write. A result leaves through a two-stage window calculation and an
// output register that may hold a result while the next items proceed. After reset the block
// clears every map entry in turn, with s_axis_tready low; configuration writes are accepted at
// any time and should be made while no item is in flight.
module descriptor_tracking_table_core #(
	parameter int NUM_SLOTS = 32,
	parameter int DESCRIPTOR_LIMIT = 1024,
	parameter int LOCK_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// descriptor [15:0], operand_value [79:16], active_in [80], zero [87:81]
	input  logic [dtt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// action [2:0]
	input  logic [dtt_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// watched [0], lock_count [8:1], is_active [9], position [73:10],
	// fuzzed_left [104:74], slot_seed [136:105], zero [143:137]
	output logic [dtt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status [1:0]
	output logic [dtt_pkg::M_TUSER_W-1:0]   m_axis_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dtt_pkg::APB_AW-1:0]      paddr,
	input  logic [dtt_pkg::APB_DW-1:0]      pwdata,
	output logic [dtt_pkg::APB_DW-1:0]      prdata,
	output logic                            pready
);
	import dtt_pkg::*;

	localparam int SLOT_AW = $clog2(NUM_SLOTS);
	localparam int MAP_AW  = $clog2(DESCRIPTOR_LIMIT);
	localparam int MAP_W   = SLOT_AW + 1;
	localparam int SLOT_W  = LOCK_BITS + 1 + POS_W + POS_W + LEN_W + SEED_W;

	// Configuration.
	logic [SEED_W-1:0] base_seed_q;
	logic              auto_inc_q;
	logic [SEED_W-1:0] next_seed_q;
	logic              cfg_wr;

	// Map clearing pass.
	logic              clr_active_q;
	logic [MAP_AW-1:0] clr_cnt_q;

	// Map write forwarding.
	logic              mw_v_q;
	logic [MAP_AW-1:0] mw_addr_q;
	logic [MAP_W-1:0]  mw_data_q;

	logic [NUM_SLOTS-1:0] slot_in_use_q;

	// Stage 1: map data is back.
	logic              s1_v_q;
	action_t           action_s1;
	logic [MAP_AW-1:0] idx_s1;
	logic              inrange_s1;
	logic [OP_W-1:0]   op_s1;
	logic              act_s1;

	// Stage 2: slot data is back, update and write-back.
	logic               s2_v_q;
	action_t            action_s2;
	logic [MAP_AW-1:0]  idx_s2;
	logic               inrange_s2;
	logic               have_s2;
	logic [SLOT_AW-1:0] slot_s2;
	logic [OP_W-1:0]    op_s2;
	logic               act_s2;
	logic               free_found_s2;
	logic [SLOT_AW-1:0] free_idx_s2;

	logic               accept;
	logic               s2_done;
	logic               rep_ready;
	logic [DESC_W-1:0]  in_desc;
	logic               in_range;

	logic               map_we;
	logic [MAP_AW-1:0]  map_waddr;
	logic [MAP_W-1:0]   map_wdata;
	logic [MAP_W-1:0]   map_rdata;
	logic [MAP_W-1:0]   map_ent;
	logic               have_s1;
	logic               free_found;
	logic [SLOT_AW-1:0] free_idx;

	logic [SLOT_W-1:0]  slot_rdata;
	logic [SLOT_W-1:0]  slot_wdata;
	logic               slot_we;

	logic [LOCK_BITS-1:0] old_locks;
	logic                 old_active;
	logic [POS_W-1:0]     old_pos;
	logic [POS_W-1:0]     old_wstart;
	logic [LEN_W-1:0]     old_wlen;
	logic [SEED_W-1:0]    old_seed;

	upd_ctl_t             ctl;
	logic [SLOT_AW-1:0]   wr_idx;
	logic [LOCK_BITS-1:0] new_locks;
	logic                 new_active;
	logic [POS_W-1:0]     new_pos;
	logic [POS_W-1:0]     new_wstart;
	logic [LEN_W-1:0]     new_wlen;
	logic [SEED_W-1:0]    new_seed;
	rep_in_t              rep;

	assign in_desc  = s_axis_tdata[DESC_W-1:0];
	assign in_range = {1'b0, in_desc} < (DESC_W + 1)'(DESCRIPTOR_LIMIT);

	assign s2_done       = s2_v_q && rep_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !clr_active_q && !s1_v_q && (!s2_v_q || rep_ready);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_BASE_SEED: prdata = base_seed_q;
			REG_AUTO_INC:  prdata = APB_DW'(auto_inc_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seed_q <= '0;
			auto_inc_q  <= 1'b0;
			next_seed_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_BASE_SEED: begin
						base_seed_q <= pwdata[SEED_W-1:0];
						next_seed_q <= pwdata[SEED_W-1:0];
					end
					REG_AUTO_INC: auto_inc_q <= pwdata[0];
					default: begin
					end
				endcase
			end else if (s2_done && ctl.seed_adv && auto_inc_q) begin
				next_seed_q <= next_seed_q + SEED_W'(1);
			end
		end
	end

	// ---------------- descriptor map ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == MAP_AW'(DESCRIPTOR_LIMIT - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
		end
	end

	assign map_we    = clr_active_q || (s2_done && ctl.map_we);
	assign map_waddr = clr_active_q ? clr_cnt_q : idx_s2;
	assign map_wdata = clr_active_q ? '0 : {ctl.map_valid, wr_idx};

	dtt_ram #(
		.WIDTH (MAP_W),
		.DEPTH (DESCRIPTOR_LIMIT)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (accept),
		.raddr (in_desc[MAP_AW-1:0]),
		.rdata (map_rdata)
	);

	// The RAM returns the old entry when it is written in the cycle of the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_v_q <= 1'b0;
		end else begin
			mw_v_q <= map_we;
		end
	end

	always_ff @(posedge clk) begin
		mw_addr_q <= map_waddr;
		mw_data_q <= map_wdata;
	end

	assign map_ent = (mw_v_q && mw_addr_q == idx_s1) ? mw_data_q : map_rdata;
	assign have_s1 = inrange_s1 && map_ent[MAP_W-1];

	// ---------------- slot pool ----------------
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!slot_in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_AW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_in_use_q <= '0;
		end else if (s2_done) begin
			if (ctl.use_set) begin
				slot_in_use_q[wr_idx] <= 1'b1;
			end
			if (ctl.use_clr) begin
				slot_in_use_q[slot_s2] <= 1'b0;
			end
		end
	end

	assign slot_we    = s2_done && ctl.slot_we;
	assign slot_wdata = {new_locks, new_active, new_pos, new_wstart, new_wlen, new_seed};

	dtt_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (wr_idx),
		.wdata (slot_wdata),
		.re    (s1_v_q),
		.raddr (map_ent[SLOT_AW-1:0]),
		.rdata (slot_rdata)
	);

	assign {old_locks, old_active, old_pos, old_wstart, old_wlen, old_seed} = slot_rdata;

	// ---------------- pipeline control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			s1_v_q <= accept;
			if (s1_v_q) begin
				s2_v_q <= 1'b1;
			end else if (s2_done) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= action_t'(s_axis_tuser);
			idx_s1     <= in_desc[MAP_AW-1:0];
			inrange_s1 <= in_range;
			op_s1      <= s_axis_tdata[DESC_W +: OP_W];
			act_s1     <= s_axis_tdata[DESC_W + OP_W];
		end
		if (s1_v_q) begin
			action_s2     <= action_s1;
			idx_s2        <= idx_s1;
			inrange_s2    <= inrange_s1;
			have_s2       <= have_s1;
			slot_s2       <= map_ent[SLOT_AW-1:0];
			op_s2         <= op_s1;
			act_s2        <= act_s1;
			free_found_s2 <= free_found;
			free_idx_s2   <= free_idx;
		end
	end

	dtt_slot_upd #(
		.LOCK_BITS (LOCK_BITS),
		.SLOT_AW   (SLOT_AW)
	) u_slot_upd (
		.action     (action_s2),
		.inrange    (inrange_s2),
		.have       (have_s2),
		.slot_idx   (slot_s2),
		.free_found (free_found_s2),
		.free_idx   (free_idx_s2),
		.operand    (op_s2),
		.act_in     (act_s2),
		.next_seed  (next_seed_q),
		.old_locks  (old_locks),
		.old_active (old_active),
		.old_pos    (old_pos),
		.old_wstart (old_wstart),
		.old_wlen   (old_wlen),
		.old_seed   (old_seed),
		.ctl        (ctl),
		.wr_idx     (wr_idx),
		.new_locks  (new_locks),
		.new_active (new_active),
		.new_pos    (new_pos),
		.new_wstart (new_wstart),
		.new_wlen   (new_wlen),
		.new_seed   (new_seed),
		.rep        (rep)
	);

	dtt_report u_report (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s2_v_q),
		.in_ready      (rep_ready),
		.in_rep        (rep),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

@@ design/dtt_props.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "descriptor_tracking_table_core_macros.svh"
module dtt_props (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dtt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input logic [dtt_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
	import dtt_pkg::*;

	`DTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

	`DTT_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// An item is never followed by another in the very next cycle.
	`DTT_ASSERT_NEXT(a_in_spacing, s_axis_tvalid && s_axis_tready, !s_axis_tready, "items accepted back to back")

	// An unwatched descriptor reports the fixed neutral values.
	`DTT_ASSERT_SAME(a_unwatched_vals, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[8:1] == '0 && m_axis_tdata[9] && m_axis_tdata[73:10] == '0 && m_axis_tdata[136:74] == '0, "unwatched result carries slot data")

	`DTT_ASSERT_SAME(a_status_watch, m_axis_tvalid && (m_axis_tuser == ST_NOT_WATCHED || m_axis_tuser == ST_NO_SLOT), !m_axis_tdata[0], "failed lookup reports a slot")

endmodule

bind descriptor_tracking_table_core dtt_props u_props (.*);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import dtt_pkg::*;

	localparam int NUM_SLOTS = 32;
	localparam int DESC_LIMIT = 1024;
	localparam logic [7:0] LOCK_MAX = 8'hFF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [APB_AW-1:0] ADDR_BASE_SEED = {REG_BASE_SEED, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_AUTO_INC = {REG_AUTO_INC, 2'b00};

	typedef struct {
		action_t act;
		logic [DESC_W-1:0] desc;
		logic [OP_W-1:0] operand;
		logic active;
	} table_op_t;

	typedef struct {
		status_t status;
		logic watched;
		logic [7:0] lock;
		logic active;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] left;
		logic [SEED_W-1:0] seed;
	} table_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	descriptor_tracking_table_core #(
		.NUM_SLOTS(NUM_SLOTS),
		.DESCRIPTOR_LIMIT(DESC_LIMIT),
		.LOCK_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the table contents and of the seed registers.
	bit map_valid [DESC_LIMIT];
	int map_slot [DESC_LIMIT];
	bit slot_used [NUM_SLOTS];
	logic [7:0] slot_lock [NUM_SLOTS];
	logic slot_act [NUM_SLOTS];
	logic [POS_W-1:0] slot_pos [NUM_SLOTS];
	logic [POS_W-1:0] win_start [NUM_SLOTS];
	logic [LEN_W-1:0] win_len [NUM_SLOTS];
	logic [SEED_W-1:0] slot_seed [NUM_SLOTS];
	logic [SEED_W-1:0] next_seed = '0;
	bit auto_inc = 1'b0;

	table_op_t pending_ops [$];
	table_report_t predicted_reports [$];
	table_op_t tx_op;
	table_report_t exp_rep;
	int tx_gap;
	int rx_wait;
	int rx_draw;
	int hold_cnt;
	bit hold_done;
	bit idle_tx = 1'b0;
	bit idle_rx = 1'b0;
	int results_seen = 0;
	int errors = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic table_report_t slot_report(status_t st, bit have, int s);
		table_report_t r;
		logic [POS_W-1:0] span;
		r.status = st;
		r.watched = have;
		r.lock = '0;
		r.active = 1'b1;
		r.pos = '0;
		r.left = '0;
		r.seed = '0;
		if (have) begin
			r.lock = slot_lock[s];
			r.active = slot_act[s];
			r.pos = slot_pos[s];
			r.seed = slot_seed[s];
			// The window counts from its start up to, not including, start plus length.
			if ($signed(slot_pos[s]) >= $signed(win_start[s])) begin
				span = slot_pos[s] - win_start[s];
				if (span < {33'd0, win_len[s]})
					r.left = win_len[s] - span[LEN_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic void apply_action(action_t act, logic [DESC_W-1:0] desc,
			logic [OP_W-1:0] val, logic act_in);
		bit in_range;
		bit have;
		int s;
		int free_slot;
		int i;
		logic [LEN_W-1:0] cnt;
		in_range = desc < DESC_LIMIT;
		have = in_range && map_valid[desc[9:0]];
		s = have ? map_slot[desc[9:0]] : 0;
		if (act == ACT_REGISTER) begin
			if (!in_range) begin
				predicted_reports.push_back(slot_report(ST_EXISTS, 1'b0, 0));
			end else if (have) begin
				predicted_reports.push_back(slot_report(ST_EXISTS, 1'b1, s));
			end else begin
				free_slot = -1;
				for (i = NUM_SLOTS - 1; i >= 0; i--)
					if (!slot_used[i])
						free_slot = i;
				if (free_slot < 0) begin
					predicted_reports.push_back(slot_report(ST_NO_SLOT, 1'b0, 0));
				end else begin
					slot_used[free_slot] = 1'b1;
					slot_lock[free_slot] = '0;
					slot_pos[free_slot] = '0;
					win_start[free_slot] = '0;
					win_len[free_slot] = '0;
					slot_seed[free_slot] = next_seed;
					slot_act[free_slot] = act_in;
					if (auto_inc)
						next_seed = next_seed + 1;
					map_valid[desc[9:0]] = 1'b1;
					map_slot[desc[9:0]] = free_slot;
					predicted_reports.push_back(slot_report(ST_OK, 1'b1, free_slot));
				end
			end
		end else if (!have) begin
			predicted_reports.push_back(slot_report(ST_NOT_WATCHED, 1'b0, 0));
		end else begin
			case (act)
				ACT_UNREGISTER: begin
					slot_used[s] = 1'b0;
					map_valid[desc[9:0]] = 1'b0;
				end
				ACT_LOCK: if (slot_lock[s] != LOCK_MAX) slot_lock[s] = slot_lock[s] + 1;
				ACT_UNLOCK: if (slot_lock[s] != 0) slot_lock[s] = slot_lock[s] - 1;
				ACT_SET_POS: slot_pos[s] = val;
				ACT_ADD_POS: slot_pos[s] = slot_pos[s] + val;
				ACT_SET_FUZZED: begin
					// Negative counts clamp to zero, large ones to the longest window.
					if (val[OP_W-1])
						cnt = '0;
					else if (val > {33'd0, LEN_MAX})
						cnt = LEN_MAX;
					else
						cnt = val[LEN_W-1:0];
					if (slot_pos[s] != win_start[s] || cnt > win_len[s]) begin
						win_start[s] = slot_pos[s];
						win_len[s] = cnt;
					end
				end
				default: ;
			endcase
			if (act == ACT_UNREGISTER)
				predicted_reports.push_back(slot_report(ST_OK, 1'b0, 0));
			else
				predicted_reports.push_back(slot_report(ST_OK, 1'b1, s));
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected, actual);
			errors++;
		end
	endfunction

	// Sender: while idle_tx is set, it waits a drawn number of cycles after each item before the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_ops.size() != 0) begin
				tx_op = pending_ops.pop_front();
				s_axis_tdata <= {7'd0, tx_op.active, tx_op.operand, tx_op.desc};
				s_axis_tuser <= tx_op.act;
				s_axis_tvalid <= 1'b1;
				tx_gap <= idle_tx ? $urandom_range(0, 3) : 0;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			apply_action(action_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[79:16],
				s_axis_tdata[80]);
	end

	// Receiver: stalls a drawn number of cycles after each item while idle_rx is set, and
	// once holds off for a long stretch so that the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= (hold_cnt == 1);
		end else if (!hold_done && results_seen >= 100) begin
			hold_done <= 1'b1;
			hold_cnt <= 300;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			rx_draw = idle_rx ? $urandom_range(0, 3) : 0;
			rx_wait <= rx_draw;
			m_axis_tready <= (rx_draw == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			m_axis_tready <= (rx_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (predicted_reports.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %h data %h",
					$time, m_axis_tuser, m_axis_tdata);
				errors++;
			end else begin
				exp_rep = predicted_reports.pop_front();
				check_field("status", exp_rep.status, m_axis_tuser);
				check_field("watched", exp_rep.watched, m_axis_tdata[0]);
				check_field("lock_count", exp_rep.lock, m_axis_tdata[8:1]);
				check_field("is_active", exp_rep.active, m_axis_tdata[9]);
				check_field("position", exp_rep.pos, m_axis_tdata[73:10]);
				check_field("fuzzed_left", exp_rep.left, m_axis_tdata[104:74]);
				check_field("slot_seed", exp_rep.seed, m_axis_tdata[136:105]);
				check_field("padding", 64'd0, m_axis_tdata[143:137]);
			end
		end
	end

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_BASE_SEED)
			next_seed = data;
		else if (addr == ADDR_AUTO_INC)
			auto_inc = data[0];
	endtask

	task automatic queue_op(action_t act, logic [DESC_W-1:0] desc, logic [OP_W-1:0] val,
			logic act_in);
		table_op_t op;
		op.act = act;
		op.desc = desc;
		op.operand = val;
		op.active = act_in;
		pending_ops.push_back(op);
	endtask

	task automatic queue_random_op();
		action_t a;
		logic [DESC_W-1:0] d;
		logic [OP_W-1:0] v;
		int r;
		r = $urandom_range(0, 99);
		if (r < 22) a = ACT_REGISTER;
		else if (r < 32) a = ACT_UNREGISTER;
		else if (r < 46) a = ACT_LOCK;
		else if (r < 56) a = ACT_UNLOCK;
		else if (r < 66) a = ACT_SET_POS;
		else if (r < 78) a = ACT_ADD_POS;
		else if (r < 92) a = ACT_SET_FUZZED;
		else a = ACT_QUERY;
		// Most items go to a small set of descriptors so that slots get reused and fill up.
		r = $urandom_range(0, 99);
		if (r < 85) begin
			d = $urandom_range(0, 47);
		end else if (r < 90) begin
			case ($urandom_range(0, 2))
				0: d = DESC_LIMIT - 1;
				1: d = DESC_LIMIT;
				default: d = 16'hFFFF;
			endcase
		end else begin
			d = $urandom_range(0, 65535);
		end
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = $urandom_range(0, 300);
			2: v = 64'($urandom_range(0, 40)) - 64'd20;
			default: begin
				case ($urandom_range(0, 5))
					0: v = 64'h7FFF_FFFF_FFFF_FFFF;
					1: v = 64'h8000_0000_0000_0000;
					2: v = {33'd0, LEN_MAX};
					3: v = {33'd0, LEN_MAX} + 64'd1;
					4: v = '1;
					default: v = '0;
				endcase
			end
		endcase
		queue_op(a, d, v, $urandom_range(0, 1));
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || s_axis_tvalid || predicted_reports.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_write(ADDR_BASE_SEED, 32'hFFFF_FFFF);
		apb_write(ADDR_AUTO_INC, 32'd1);
		@(negedge clk);
		queue_op(ACT_QUERY, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_REGISTER, 16'd5, 64'd0, 1'b1);
		queue_op(ACT_REGISTER, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_REGISTER, DESC_LIMIT, 64'd0, 1'b1);
		queue_op(ACT_REGISTER, 16'hFFFF, 64'd0, 1'b0);
		queue_op(ACT_LOCK, 16'hFFFF, 64'd0, 1'b0);
		queue_op(ACT_LOCK, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_LOCK, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_UNLOCK, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_UNLOCK, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_UNLOCK, 16'd5, 64'd0, 1'b0);
		// Position wraps from the largest value to the smallest.
		queue_op(ACT_SET_POS, 16'd5, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		queue_op(ACT_ADD_POS, 16'd5, 64'd1, 1'b0);
		queue_op(ACT_SET_FUZZED, 16'd5, '1, 1'b0);
		queue_op(ACT_SET_FUZZED, 16'd5, 64'h1_0000_0000, 1'b0);
		queue_op(ACT_ADD_POS, 16'd5, 64'd100, 1'b0);
		queue_op(ACT_SET_FUZZED, 16'd5, 64'd10, 1'b0);
		queue_op(ACT_SET_FUZZED, 16'd5, 64'd5, 1'b0);
		// Walk to the last byte of the window, past its end, then before its start.
		queue_op(ACT_ADD_POS, 16'd5, 64'd9, 1'b0);
		queue_op(ACT_ADD_POS, 16'd5, 64'd1, 1'b0);
		queue_op(ACT_ADD_POS, 16'd5, -64'sd20, 1'b0);
		queue_op(ACT_REGISTER, 16'd0, 64'd0, 1'b0);
		queue_op(ACT_UNREGISTER, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_QUERY, 16'd5, 64'd0, 1'b0);
		queue_op(ACT_REGISTER, DESC_LIMIT - 1, 64'd0, 1'b1);
		queue_op(ACT_QUERY, DESC_LIMIT - 1, 64'd0, 1'b0);
		queue_op(ACT_UNREGISTER, DESC_LIMIT, 64'd0, 1'b0);
		drain();

		apb_write(ADDR_BASE_SEED, 32'h7FFF_FFFF);
		@(negedge clk);
		idle_tx = 1'b1;
		idle_rx = 1'b1;
		repeat (200) queue_random_op();
		drain();

		// Free the whole pool, then drive one slot's lock count into its upper limit and back down.
		apb_write(ADDR_BASE_SEED, 32'h8000_0000);
		apb_write(ADDR_AUTO_INC, 32'd0);
		@(negedge clk);
		idle_tx = 1'b0;
		idle_rx = 1'b0;
		for (int d = 0; d < DESC_LIMIT; d++)
			if (map_valid[d])
				queue_op(ACT_UNREGISTER, d, {$urandom, $urandom}, 1'b0);
		queue_op(ACT_REGISTER, 16'd700, 64'd0, 1'b1);
		repeat (258) queue_op(ACT_LOCK, 16'd700, {$urandom, $urandom}, $urandom_range(0, 1));
		repeat (3) queue_op(ACT_UNLOCK, 16'd700, 64'd0, 1'b0);
		queue_op(ACT_QUERY, 16'd700, 64'd0, 1'b0);
		drain();

		apb_write(ADDR_BASE_SEED, $urandom);
		apb_write(ADDR_AUTO_INC, 32'd1);
		@(negedge clk);
		idle_tx = 1'b1;
		idle_rx = 1'b1;
		for (int i = 0; i < NUM_SLOTS + 2; i++)
			queue_op(ACT_REGISTER, 16'd100 + i, 64'd0, $urandom_range(0, 1));
		repeat (130) queue_random_op();
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+design
design/dtt_pkg.sv
design/dtt_ram.sv
design/dtt_slot_upd.sv
design/dtt_report.sv
design/descriptor_tracking_table_core.sv
design/dtt_props.sv
tb/testbench.sv
